// File: sv/qdp_pkg.sv
// ----------------------------------------------------------------------------
// qdp_pkg
// Shared widths, constants and the queue entry type of the quantized dot
// product unit.
// ----------------------------------------------------------------------------
package qdp_pkg;

  localparam int QUERY_BITS   = 16;
  localparam int CODE_BITS    = 8;
  localparam int SCALE_BITS   = 24;
  localparam int SUM_BITS     = 40;
  localparam int PROD_BITS    = QUERY_BITS + CODE_BITS;
  localparam int SCORE_BITS   = SUM_BITS + SCALE_BITS;
  localparam int SPLIT_BITS   = SUM_BITS / 2;
  localparam int LO_BITS      = SPLIT_BITS + 1 + SCALE_BITS;
  localparam int HI_BITS      = (SUM_BITS - SPLIT_BITS) + SCALE_BITS;

  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_BITS     = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CODE4_MASK   = 8'h0f;
  localparam logic [7:0] CODE4_BIAS   = 8'd8;
  localparam int         NIBBLE_SHIFT = 4;

  localparam logic MODE_INT8 = 1'b0;
  localparam logic MODE_INT4 = 1'b1;

  // One decoded dimension, as queued between front and back
  typedef struct packed {
    logic signed [QUERY_BITS-1:0] query;
    logic signed [CODE_BITS-1:0]  code;
    logic signed [SCALE_BITS-1:0] scale;
    logic                         last;
  } entry_t;

endpackage

// File: sv/qdp_front.sv
// ----------------------------------------------------------------------------
// qdp_front
// Accepts input transactions, holds the code mode register and dimension
// parity, and decodes each code byte into a signed code for the queue.
// ----------------------------------------------------------------------------
module qdp_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 q_full,
  input  logic                                 cfg_write,
  input  logic                                 cfg_data,
  input  logic signed [qdp_pkg::QUERY_BITS-1:0] query_value,
  input  logic        [qdp_pkg::CODE_BITS-1:0]  code_byte,
  input  logic signed [qdp_pkg::SCALE_BITS-1:0] scale_value,
  input  logic                                 last,
  output logic                                 q_push,
  output qdp_pkg::entry_t                      q_entry
);

  logic                      code_mode;
  logic                      odd_dimension;
  logic [qdp_pkg::CODE_BITS-1:0] nib_byte;
  logic [qdp_pkg::CODE_BITS-1:0] code;

  assign q_push = push && !q_full;

  // Decode: signed byte, or nibble picked by parity minus the bias of eight
  always_comb begin
    if (odd_dimension) begin
      nib_byte = (code_byte >> qdp_pkg::NIBBLE_SHIFT) & qdp_pkg::CODE4_MASK;
    end else begin
      nib_byte = code_byte & qdp_pkg::CODE4_MASK;
    end
    if (code_mode == qdp_pkg::MODE_INT8) begin
      code = code_byte;
    end else begin
      code = nib_byte - qdp_pkg::CODE4_BIAS;
    end
  end

  always_comb begin
    q_entry.query = query_value;
    q_entry.code  = $signed(code);
    q_entry.scale = scale_value;
    q_entry.last  = last;
  end

  // Hold mode; advance parity per transaction, drop it on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      code_mode     <= qdp_pkg::MODE_INT8;
      odd_dimension <= 1'b0;
    end else begin
      if (cfg_write) begin
        code_mode <= cfg_data;
      end
      if (q_push) begin
        odd_dimension <= last ? 1'b0 : !odd_dimension;
      end
    end
  end

endmodule

// File: sv/qdp_fifo.sv
// ----------------------------------------------------------------------------
// qdp_fifo
// Short queue of decoded dimensions between the front and the back.
// ----------------------------------------------------------------------------
module qdp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  qdp_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            rd_en,
  output qdp_pkg::entry_t rd_entry,
  output logic            empty
);

  qdp_pkg::entry_t                 slots [qdp_pkg::FIFO_DEPTH];
  logic [qdp_pkg::PTR_BITS-1:0]    wr_ptr;
  logic [qdp_pkg::PTR_BITS-1:0]    rd_ptr;
  logic [qdp_pkg::CNT_BITS-1:0]    count;

  assign full     = (count == qdp_pkg::CNT_BITS'(qdp_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/qdp_back.sv
// ----------------------------------------------------------------------------
// qdp_back
// Multiplies query by code, accumulates the exact sum, and on the last
// dimension scales it in two partial products into the result register.
// ----------------------------------------------------------------------------
module qdp_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  input  qdp_pkg::entry_t                       q_entry,
  output logic                                  q_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [qdp_pkg::SCORE_BITS-1:0] score
);

  typedef enum logic [3:0] {
    ST_RUN = 4'b0001,
    ST_LO  = 4'b0010,
    ST_HI  = 4'b0100,
    ST_ADD = 4'b1000
  } state_t;

  state_t                                 state;
  logic                                   prod_valid;
  logic                                   prod_last;
  logic signed [qdp_pkg::PROD_BITS-1:0]   prod;
  logic signed [qdp_pkg::SCALE_BITS-1:0]  prod_scale;
  logic        [qdp_pkg::SUM_BITS-1:0]    sum;
  logic        [qdp_pkg::SUM_BITS-1:0]    sum_next;
  logic        [qdp_pkg::SUM_BITS-1:0]    fin_sum;
  logic signed [qdp_pkg::SCALE_BITS-1:0]  fin_scale;
  logic signed [qdp_pkg::LO_BITS-1:0]     lo_part;
  logic signed [qdp_pkg::HI_BITS-1:0]     hi_part;
  logic                                   out_full;
  logic                                   out_load;

  // Pop while running, but not behind a pending last dimension
  assign q_pop    = (state == ST_RUN) && !q_empty && !(prod_valid && prod_last);
  assign sum_next = sum + qdp_pkg::SUM_BITS'(prod);
  assign out_load = (state == ST_ADD) && (!out_full || pop);
  assign empty    = !out_full;

  // Product stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod       <= q_entry.query * q_entry.code;
      prod_last  <= q_entry.last;
      prod_scale <= q_entry.scale;
    end
  end

  // Sequence accumulate and scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      prod_valid <= 1'b0;
      sum        <= '0;
      out_full   <= 1'b0;
    end else begin
      prod_valid <= q_pop;
      case (state)
        ST_RUN: begin
          if (prod_valid) begin
            if (prod_last) begin
              sum   <= '0;
              state <= ST_LO;
            end else begin
              sum <= sum_next;
            end
          end
        end
        ST_LO:   state <= ST_HI;
        ST_HI:   state <= ST_ADD;
        ST_ADD: begin
          if (out_load) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
      if (out_load) begin
        out_full <= 1'b1;
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

  // Final sum and scale, then the two partial products and their sum
  always_ff @(posedge clk) begin
    if ((state == ST_RUN) && prod_valid && prod_last) begin
      fin_sum   <= sum_next;
      fin_scale <= prod_scale;
    end
    if (state == ST_LO) begin
      lo_part <= $signed({1'b0, fin_sum[qdp_pkg::SPLIT_BITS-1:0]}) * fin_scale;
    end
    if (state == ST_HI) begin
      hi_part <= $signed(fin_sum[qdp_pkg::SUM_BITS-1:qdp_pkg::SPLIT_BITS]) * fin_scale;
    end
    if (out_load) begin
      score <= $signed({hi_part, {qdp_pkg::SPLIT_BITS{1'b0}}})
             + qdp_pkg::SCORE_BITS'(lo_part);
    end
  end

endmodule

// File: sv/quantized_dot_product_unit.sv
// ----------------------------------------------------------------------------
// quantized_dot_product_unit
// Streams one dimension per transaction, accumulates query times code and
// emits the scaled score on the dimension marked last.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  input     push / full       query_value, code_byte, scale_value, last
//  result    empty / pop       score
//  config    cfg_write         cfg_data (code_mode)
//
//  One dimension a cycle is taken while the back is accumulating; the
//  product stage and accumulator keep up with the four-entry queue.
//  A last dimension holds the back through the accumulate, low and high
//  partial product and final add states, longer while a score sits unread.
//  The front keeps accepting into the queue during that time until full.
//  Reset clears mode, parity, sum and queue and marks the result empty.
// ----------------------------------------------------------------------------
module quantized_dot_product_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [qdp_pkg::QUERY_BITS-1:0] query_value,
  input  logic        [qdp_pkg::CODE_BITS-1:0]  code_byte,
  input  logic signed [qdp_pkg::SCALE_BITS-1:0] scale_value,
  input  logic                                  last,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [qdp_pkg::SCORE_BITS-1:0] score,
  input  logic                                  cfg_write,
  input  logic                                  cfg_data
);

  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  qdp_pkg::entry_t q_wr_entry;
  qdp_pkg::entry_t q_rd_entry;

  qdp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .q_full       (full),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .query_value  (query_value),
    .code_byte    (code_byte),
    .scale_value  (scale_value),
    .last         (last),
    .q_push       (q_push),
    .q_entry      (q_wr_entry)
  );

  qdp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (q_wr_entry),
    .full     (full),
    .rd_en    (q_pop),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  qdp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (q_rd_entry),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .score   (score)
  );

  // Back never drains an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A full queue holds entries
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_empty)
    else $error("queue full and empty at once");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

endmodule

// File: tb/sv/qdp_score_checker.sv
// ----------------------------------------------------------------------------
// qdp_score_checker
// Watches the dimension, result and mode channels of the quantized dot
// product unit. It keeps its own running sum, parity and code mode, works
// out the score of every vector, and compares each popped score with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
module qdp_score_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic                                  full,
  input  logic signed [qdp_pkg::QUERY_BITS-1:0] query_value,
  input  logic        [qdp_pkg::CODE_BITS-1:0]  code_byte,
  input  logic signed [qdp_pkg::SCALE_BITS-1:0] scale_value,
  input  logic                                  last,
  input  logic                                  empty,
  input  logic                                  pop,
  input  logic signed [qdp_pkg::SCORE_BITS-1:0] score,
  input  logic                                  cfg_write,
  input  logic                                  cfg_data,
  output int                                    fail_count,
  output int                                    scores_pending,
  output int                                    scores_checked
);

  localparam int MAX_REPORTS = 10;

  logic                                  code_mode;
  logic                                  odd_dim;
  logic signed [qdp_pkg::SUM_BITS-1:0]   dot_sum;
  logic signed [qdp_pkg::SCORE_BITS-1:0] expected_scores[$];

  // Count a failure and print the first few
  task automatic flag_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Decode one code, add query times code, close the vector on last
  task automatic accumulate_dimension(input logic signed [qdp_pkg::QUERY_BITS-1:0] q,
                                      input logic [qdp_pkg::CODE_BITS-1:0] b,
                                      input logic signed [qdp_pkg::SCALE_BITS-1:0] s,
                                      input logic l);
    logic [qdp_pkg::CODE_BITS-1:0]         nib;
    logic signed [qdp_pkg::CODE_BITS-1:0]  code;
    logic signed [qdp_pkg::PROD_BITS-1:0]  prod;
    logic signed [qdp_pkg::SCORE_BITS-1:0] wide_sum;
    logic signed [qdp_pkg::SCORE_BITS-1:0] wide_scale;
    if (code_mode == qdp_pkg::MODE_INT8) begin
      code = signed'(b);
    end else begin
      // Packed nibbles: low on even dimensions, high on odd ones
      nib  = odd_dim ? ((b >> qdp_pkg::NIBBLE_SHIFT) & qdp_pkg::CODE4_MASK)
                     : (b & qdp_pkg::CODE4_MASK);
      code = signed'(nib - qdp_pkg::CODE4_BIAS);
    end
    prod    = q * code;
    dot_sum = dot_sum + prod;
    odd_dim = ~odd_dim;
    if (l) begin
      wide_sum   = dot_sum;
      wide_scale = s;
      expected_scores.push_back(wide_sum * wide_scale);
      dot_sum = '0;
      odd_dim = 1'b0;
    end
  endtask

  // Compare a popped score with the oldest outstanding one
  task automatic check_score(input logic signed [qdp_pkg::SCORE_BITS-1:0] got);
    logic signed [qdp_pkg::SCORE_BITS-1:0] want;
    scores_checked++;
    if (expected_scores.size() == 0) begin
      flag_mismatch($sformatf("score %0d popped with no vector outstanding", got));
    end else begin
      want = expected_scores.pop_front();
      if (got !== want) begin
        flag_mismatch($sformatf("score %0d, expected %0d", got, want));
      end
    end
  endtask

  // Sample every channel at the edge, mode write first
  always @(posedge clk) begin
    if (rst) begin
      code_mode      = qdp_pkg::MODE_INT8;
      odd_dim        = 1'b0;
      dot_sum        = '0;
      fail_count     = 0;
      scores_checked = 0;
      expected_scores.delete();
    end else begin
      if (cfg_write) begin
        code_mode = cfg_data;
      end
      if (push && !full) begin
        accumulate_dimension(query_value, code_byte, scale_value, last);
      end
      if (pop && !empty) begin
        check_score(score);
      end
    end
    scores_pending = expected_scores.size();
  end

endmodule

// File: tb/sv/tb_quantized_dot_product_unit.sv
// ----------------------------------------------------------------------------
// tb_quantized_dot_product_unit
// Drives dimension streams into the quantized dot product unit in both code
// modes: directed extremes and mode switches inside a vector, a long vector
// of full-scale products, then random vectors with random idling on both
// sides and a long result hold-off. A checker beside the unit scores them.
// ----------------------------------------------------------------------------
module tb_quantized_dot_product_unit;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int RANDOM_DIMS   = 1050;
  localparam int LONG_DIMS     = 128;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  push = 1'b0;
  logic                                  full;
  logic signed [qdp_pkg::QUERY_BITS-1:0] query_value = '0;
  logic        [qdp_pkg::CODE_BITS-1:0]  code_byte = '0;
  logic signed [qdp_pkg::SCALE_BITS-1:0] scale_value = '0;
  logic                                  last = 1'b0;
  logic                                  empty;
  logic                                  pop = 1'b0;
  logic signed [qdp_pkg::SCORE_BITS-1:0] score;
  logic                                  cfg_write = 1'b0;
  logic                                  cfg_data = 1'b0;

  int   fail_count;
  int   scores_pending;
  int   scores_checked;
  int   cycle_count = 0;
  int   dims_sent = 0;
  int   vectors_sent = 0;
  int   hold_len = 0;
  logic calm = 1'b0;
  logic mode_now = qdp_pkg::MODE_INT8;

  quantized_dot_product_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .query_value  (query_value),
    .code_byte    (code_byte),
    .scale_value  (scale_value),
    .last         (last),
    .empty        (empty),
    .pop          (pop),
    .score        (score),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  qdp_score_checker score_chk (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .query_value    (query_value),
    .code_byte      (code_byte),
    .scale_value    (scale_value),
    .last           (last),
    .empty          (empty),
    .pop            (pop),
    .score          (score),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .scores_pending (scores_pending),
    .scores_checked (scores_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("cycle limit hit with %0d scores outstanding", scores_pending);
      $display("quantized_dot_product_unit test failed");
      $finish;
    end
  end

  // Result side: random pops, or a long hold-off when one is requested
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        pop <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        pop <= calm || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  function automatic logic signed [qdp_pkg::QUERY_BITS-1:0] pick_query();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(qdp_pkg::QUERY_BITS-1){1'b1}}};
      1:       return {1'b1, {(qdp_pkg::QUERY_BITS-1){1'b0}}};
      default: return qdp_pkg::QUERY_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [qdp_pkg::SCALE_BITS-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(qdp_pkg::SCALE_BITS-1){1'b1}}};
      1:       return {1'b1, {(qdp_pkg::SCALE_BITS-1){1'b0}}};
      default: return qdp_pkg::SCALE_BITS'($urandom);
    endcase
  endfunction

  // Offer one dimension, hold it until taken, then maybe idle
  task automatic send_dim(input logic signed [qdp_pkg::QUERY_BITS-1:0] q,
                          input logic [qdp_pkg::CODE_BITS-1:0] b,
                          input logic signed [qdp_pkg::SCALE_BITS-1:0] s,
                          input logic l);
    query_value  <= q;
    code_byte    <= b;
    scale_value  <= s;
    last         <= l;
    push         <= 1'b1;
    do @(posedge clk); while (full);
    dims_sent++;
    if (l) begin
      vectors_sent++;
    end
    if (!calm && $urandom_range(0, 99) < 19) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every score is out and the unit is quiet
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (scores_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_now = m;
  endtask

  // One vector; in packed mode the byte mostly repeats for the odd dimension
  task automatic send_vector(input int len, input int switch_at);
    logic [qdp_pkg::CODE_BITS-1:0] b;
    b = '0;
    for (int i = 0; i < len; i++) begin
      if (i == switch_at) begin
        set_mode(~mode_now);
      end
      if (mode_now == qdp_pkg::MODE_INT8 || i % 2 == 0 || $urandom_range(0, 9) == 0) begin
        b = qdp_pkg::CODE_BITS'($urandom_range(0, 255));
      end
      send_dim(pick_query(), b, pick_scale(), i == len - 1);
    end
  endtask

  initial begin
    int random_start;
    int len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Signed codes at the extremes, full-scale scales
    set_mode(qdp_pkg::MODE_INT8);
    send_dim(16'sh7fff, 8'h7f, 24'sh000001, 1'b0);
    send_dim(16'sh8000, 8'h80, 24'sh7fffff, 1'b0);
    send_dim(16'sh8000, 8'h7f, 24'sh000000, 1'b0);
    send_dim(16'sh0000, 8'hff, 24'sh7fffff, 1'b1);
    send_dim(16'sh8000, 8'h80, 24'sh800000, 1'b1);
    send_dim(16'shffff, 8'h01, 24'shffffff, 1'b1);
    // Parity still advances in signed mode; switch to packed mid-vector
    send_dim(16'sh1234, 8'h55, 24'sh000000, 1'b0);
    set_mode(qdp_pkg::MODE_INT4);
    send_dim(16'sh7fff, 8'hf0, 24'sh000000, 1'b0);
    send_dim(16'sh8000, 8'h0f, 24'sh000000, 1'b0);
    send_dim(16'sh8000, 8'h0f, 24'sh000000, 1'b0);
    send_dim(16'sh7fff, 8'h00, 24'sh7fffff, 1'b1);
    send_dim(16'sh7fff, 8'hf0, 24'sh800000, 1'b1);
    send_dim(16'sh0001, 8'h8f, 24'sh000000, 1'b0);
    send_dim(16'shffff, 8'h8f, 24'sh000001, 1'b1);
    // Packed to signed mid-vector, parity carried over
    send_dim(16'sh4000, 8'ha5, 24'sh000000, 1'b0);
    set_mode(qdp_pkg::MODE_INT8);
    send_dim(16'shc000, 8'ha5, 24'sh010000, 1'b1);

    // Long vector of full-scale products, no idling
    calm = 1'b1;
    for (int i = 0; i < LONG_DIMS; i++) begin
      send_dim(16'sh8000, 8'h80, 24'sh7fffff, i == LONG_DIMS - 1);
    end
    calm = 1'b0;
    drain();

    // Random vectors; start with the result side held off
    random_start = dims_sent;
    hold_len = HOLD_CYCLES;
    while (dims_sent - random_start < RANDOM_DIMS) begin
      if (dims_sent - random_start < 150) begin
        len = $urandom_range(1, 3);
      end else if ($urandom_range(0, 99) < 70) begin
        len = $urandom_range(1, 8);
      end else if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(9, 32);
      end else begin
        len = $urandom_range(33, 128);
      end
      calm = (dims_sent - random_start >= 500) && (dims_sent - random_start < 700);
      if (dims_sent - random_start >= 150 && $urandom_range(0, 11) == 0) begin
        set_mode(1'($urandom_range(0, 1)));
      end
      if (len > 1 && $urandom_range(0, 19) == 0) begin
        send_vector(len, $urandom_range(1, len - 1));
      end else begin
        send_vector(len, -1);
      end
      if (dims_sent - random_start >= 300 && dims_sent - random_start < 300 + len) begin
        drain();
      end
    end
    calm = 1'b0;

    push <= 1'b0;
    do @(negedge clk); while (scores_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d dimensions in %0d vectors over both code modes; %0d scores compared.",
             dims_sent, vectors_sent, scores_checked);
    $display("Covered a %0d-dimension full-scale vector and a %0d-cycle result hold-off.",
             LONG_DIMS, HOLD_CYCLES);
    if (fail_count == 0 && scores_pending == 0) begin
      $display("quantized_dot_product_unit test passed");
    end else begin
      $display("quantized_dot_product_unit test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/qdp_pkg.sv
sv/qdp_front.sv
sv/qdp_fifo.sv
sv/qdp_back.sv
sv/quantized_dot_product_unit.sv
tb/sv/qdp_score_checker.sv
tb/sv/tb_quantized_dot_product_unit.sv
